// ===== design/kpc_pkg.sv =====
package kpc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CrcW = 16;
  localparam int unsigned IndexW = 9;
  localparam logic [CrcW-1:0] CRC_POLY = 16'h1021;
  localparam logic [ByteW-1:0] MAX_DATA_LEN_RESET = 8'd94;
  localparam logic [IndexW-1:0] INDEX_SAT = 9'd511;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
    logic [ByteW-1:0] expected_seq;
    logic [ByteW-1:0] expected_type;
  } item_t;

  typedef struct packed {
    logic             packet_ok;
    logic             length_ok;
    logic             check_ok;
    logic             seq_match;
    logic             type_match;
    logic [CrcW-1:0]  computed_crc;
    logic [ByteW-1:0] packet_seq;
    logic [ByteW-1:0] packet_type;
  } verdict_t;

  // CRC-16, MSB first, one byte
  function automatic logic [CrcW-1:0] crc_step(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/kpc_in_stage.sv =====
module kpc_in_stage import kpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  held_valid,
  output item_t held_item
);

  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_hold_unconsumed: assert property (@(posedge clk) disable iff (rst)
    held_valid && !advance |=> held_valid && $stable(held_item))
    else $error("unconsumed request lost from input register");
`endif

endmodule

// ===== design/kpc_field_track.sv =====
module kpc_field_track import kpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ByteW-1:0] max_data_len,
  input  item_t            item,
  input  logic             step,
  output verdict_t         verdict
);

  logic [IndexW-1:0] byte_index, byte_index_next;
  logic [CrcW-1:0]   crc_reg, crc_reg_next;
  logic [ByteW-1:0]  length_field, length_field_next;
  logic [ByteW-1:0]  seq_field, seq_field_next;
  logic [ByteW-1:0]  type_field, type_field_next;
  logic [CrcW-1:0]   received_check, received_check_next;
  logic [1:0]        check_bytes_seen, check_bytes_seen_next;

  logic [ByteW:0]    max_len;
  logic              len_ok, long_enough, chk_ok;

  always_comb begin
    byte_index_next       = byte_index;
    crc_reg_next          = crc_reg;
    length_field_next     = length_field;
    seq_field_next        = seq_field;
    type_field_next       = type_field;
    received_check_next   = received_check;
    check_bytes_seen_next = check_bytes_seen;
    if (item.last_byte) begin
      // end mark: clear for the next packet
      byte_index_next       = '0;
      crc_reg_next          = '0;
      length_field_next     = '0;
      seq_field_next        = '0;
      type_field_next       = '0;
      received_check_next   = '0;
      check_bytes_seen_next = '0;
    end else begin
      if (byte_index == '0) begin
        crc_reg_next = crc_step('0, item.data_byte);
      end else if (byte_index == IndexW'(1)) begin
        length_field_next = item.data_byte;
        if (item.data_byte < 8'd2) begin
          crc_reg_next = '0;
        end else if (item.data_byte >= 8'd3) begin
          crc_reg_next = crc_step(crc_reg, item.data_byte);
        end
      end else begin
        if (byte_index == IndexW'(2)) seq_field_next = item.data_byte;
        if (byte_index == IndexW'(3)) type_field_next = item.data_byte;
        if (({1'b0, byte_index} + 10'd1) < {2'b00, length_field}) begin
          crc_reg_next = crc_step(crc_reg, item.data_byte);
        end
      end
      received_check_next = {item.data_byte, received_check[CrcW-1:ByteW]};
      if (check_bytes_seen != 2'd2) check_bytes_seen_next = check_bytes_seen + 2'd1;
      if (byte_index != INDEX_SAT) byte_index_next = byte_index + IndexW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      crc_reg          <= '0;
      length_field     <= '0;
      seq_field        <= '0;
      type_field       <= '0;
      received_check   <= '0;
      check_bytes_seen <= '0;
    end else if (step) begin
      byte_index       <= byte_index_next;
      crc_reg          <= crc_reg_next;
      length_field     <= length_field_next;
      seq_field        <= seq_field_next;
      type_field       <= type_field_next;
      received_check   <= received_check_next;
      check_bytes_seen <= check_bytes_seen_next;
    end
  end

  assign max_len     = {1'b0, max_data_len} + 9'd7;
  assign len_ok      = (length_field >= 8'd5) && ({1'b0, length_field} <= max_len);
  assign long_enough = (check_bytes_seen == 2'd2) &&
                       (byte_index >= ({1'b0, length_field} + 9'd1));
  assign chk_ok      = long_enough && (received_check == crc_reg);

  always_comb begin
    verdict.packet_ok    = len_ok && chk_ok;
    verdict.length_ok    = len_ok;
    verdict.check_ok     = chk_ok;
    verdict.seq_match    = (seq_field == item.expected_seq);
    verdict.type_match   = (type_field == item.expected_type);
    verdict.computed_crc = crc_reg;
    verdict.packet_seq   = seq_field;
    verdict.packet_type  = type_field;
  end

`ifndef SYNTHESIS
  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    check_bytes_seen != 2'd3)
    else $error("check byte count ran past two");
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> byte_index == '0 && crc_reg == '0 && check_bytes_seen == '0)
    else $error("packet state not cleared after end mark");
  a_seen_tracks_index: assert property (@(posedge clk) disable iff (rst)
    byte_index >= IndexW'(2) |-> check_bytes_seen == 2'd2)
    else $error("check byte count out of step with byte index");
`endif

endmodule

// ===== design/kpc_out_stage.sv =====
module kpc_out_stage import kpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  verdict_t verdict_in,
  output logic     ready,
  output logic     out_valid,
  input  logic     out_stall,
  output verdict_t verdict_out
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && ready) begin
      verdict_out <= verdict_in;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> ready)
    else $error("result register loaded while a result is stalled");
`endif

endmodule

// ===== design/kermit_packet_checker_core.sv =====
// Received-packet checker for mini-Kermit, CRC-16 (poly 0x1021, init 0).
// Input channel: one packet byte per request on in_valid/in_stall with
// data_byte; last_byte flags the end mark, and expected_seq/expected_type
// are sampled with that request only. Output channel: one result request
// per packet on out_valid/out_stall, issued for the end mark alone.
// cfg_write/cfg_data set the maximum data length (reset 94); write it only
// while no packet is in progress.
// Path: a byte taken is held in the input register, then folded into
// the CRC in the packet state registers; an end mark instead loads the
// result register, which offers the result on out_valid.
// Throughput: one byte per cycle unless an end mark waits on a stalled
// result, set by the single-byte CRC update into the packet state.
// Stall: while out_stall holds a pending result, data bytes still advance;
// only a following end mark waits, and in_stall then rises.
// Reset (rst, synchronous): drop any held request and result, clear the
// packet state, restore the maximum length to MaxDataLenReset (default 94).
module kermit_packet_checker_core import kpc_pkg::*; #(
  parameter logic [ByteW-1:0] MaxDataLenReset = MAX_DATA_LEN_RESET
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [ByteW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  input  logic [ByteW-1:0] expected_seq,
  input  logic [ByteW-1:0] expected_type,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             packet_ok,
  output logic             length_ok,
  output logic             check_ok,
  output logic             seq_match,
  output logic             type_match,
  output logic [CrcW-1:0]  computed_crc,
  output logic [ByteW-1:0] packet_seq,
  output logic [ByteW-1:0] packet_type
);

  logic [ByteW-1:0] max_data_len;
  item_t            in_item, held_item;
  logic             held_valid, advance, out_ready;
  verdict_t         verdict, result;

  // maximum data length register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_data_len <= MaxDataLenReset;
    end else if (cfg_write) begin
      max_data_len <= cfg_data;
    end
  end

  assign in_item = '{data_byte: data_byte, last_byte: last_byte,
                     expected_seq: expected_seq, expected_type: expected_type};

  // a data byte always advances; an end mark needs room in the result register
  assign advance = held_valid && (!held_item.last_byte || out_ready);

  kpc_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .advance   (advance),
    .held_valid(held_valid),
    .held_item (held_item)
  );

  kpc_field_track u_track (
    .clk         (clk),
    .rst         (rst),
    .max_data_len(max_data_len),
    .item        (held_item),
    .step        (advance),
    .verdict     (verdict)
  );

  kpc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && held_item.last_byte),
    .verdict_in (verdict),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .verdict_out(result)
  );

  assign packet_ok    = result.packet_ok;
  assign length_ok    = result.length_ok;
  assign check_ok     = result.check_ok;
  assign seq_match    = result.seq_match;
  assign type_match   = result.type_match;
  assign computed_crc = result.computed_crc;
  assign packet_seq   = result.packet_seq;
  assign packet_type  = result.packet_type;

`ifndef SYNTHESIS
  a_result_needs_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(held_valid && held_item.last_byte))
    else $error("result raised without an end mark");
  a_ok_is_and: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> packet_ok == (length_ok && check_ok))
    else $error("packet_ok disagrees with length and check verdicts");
`endif

endmodule

// ===== tb/kpc_verdict_checker.sv =====
`timescale 1ns / 100ps

package kpc_crc_pkg;
  import kpc_pkg::*;

  // Bit-serial CRC-16, MSB first: feed one data bit per shift.
  function automatic logic [CrcW-1:0] crc16_fold(input logic [CrcW-1:0] acc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] r;
    logic            fb;
    r = acc;
    for (int k = ByteW - 1; k >= 0; k--) begin
      fb = r[CrcW-1] ^ b[k];
      r = r << 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

module kpc_verdict_checker import kpc_pkg::*, kpc_crc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [ByteW-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ByteW-1:0] data_byte,
  input  logic             last_byte,
  input  logic [ByteW-1:0] expected_seq,
  input  logic [ByteW-1:0] expected_type,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic             packet_ok,
  input  logic             length_ok,
  input  logic             check_ok,
  input  logic             seq_match,
  input  logic             type_match,
  input  logic [CrcW-1:0]  computed_crc,
  input  logic [ByteW-1:0] packet_seq,
  input  logic [ByteW-1:0] packet_type,
  output int               mismatches,
  output int               pending,
  output int               compared
);

  logic [ByteW-1:0]  max_len;
  logic [IndexW-1:0] seen;
  logic [CrcW-1:0]   crc_acc;
  logic [ByteW-1:0]  len_fld;
  logic [ByteW-1:0]  seq_fld;
  logic [ByteW-1:0]  type_fld;
  logic [CrcW-1:0]   tail_check;
  logic [1:0]        tail_count;
  verdict_t          awaited_verdicts[$];

  task automatic report(input string what);
    if (mismatches < 50) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  task automatic clear_packet();
    seen = '0;
    crc_acc = '0;
    len_fld = '0;
    seq_fld = '0;
    type_fld = '0;
    tail_check = '0;
    tail_count = '0;
  endtask

  task automatic absorb_byte();
    verdict_t v;
    logic     enough;
    if (!last_byte) begin
      if (seen == 0) begin
        crc_acc = crc16_fold('0, data_byte);
      end else if (seen == 1) begin
        len_fld = data_byte;
        if (data_byte < 2) begin
          crc_acc = '0;
        end else if (data_byte >= 3) begin
          crc_acc = crc16_fold(crc_acc, data_byte);
        end
      end else begin
        if (seen == 2) begin
          seq_fld = data_byte;
        end
        if (seen == 3) begin
          type_fld = data_byte;
        end
        if (int'(seen) + 1 < int'(len_fld)) begin
          crc_acc = crc16_fold(crc_acc, data_byte);
        end
      end
      tail_check = {data_byte, tail_check[CrcW-1:ByteW]};
      if (tail_count < 2) begin
        tail_count++;
      end
      if (seen != INDEX_SAT) begin
        seen++;
      end
    end else begin
      enough = (tail_count == 2) && (int'(seen) >= int'(len_fld) + 1);
      v.length_ok = (len_fld >= 5) && (int'(len_fld) <= int'(max_len) + 7);
      v.check_ok = enough && (tail_check == crc_acc);
      v.packet_ok = v.length_ok && v.check_ok;
      v.seq_match = (seq_fld == expected_seq);
      v.type_match = (type_fld == expected_type);
      v.computed_crc = crc_acc;
      v.packet_seq = seq_fld;
      v.packet_type = type_fld;
      awaited_verdicts.push_back(v);
      pending++;
      clear_packet();
    end
  endtask

  task automatic compare_verdict();
    verdict_t want;
    if (awaited_verdicts.size() == 0) begin
      report("result with no packet awaiting a verdict");
    end else begin
      want = awaited_verdicts.pop_front();
      pending--;
      compared++;
      if (packet_ok !== want.packet_ok)
        report($sformatf("packet_ok %0b, want %0b", packet_ok, want.packet_ok));
      if (length_ok !== want.length_ok)
        report($sformatf("length_ok %0b, want %0b", length_ok, want.length_ok));
      if (check_ok !== want.check_ok)
        report($sformatf("check_ok %0b, want %0b", check_ok, want.check_ok));
      if (seq_match !== want.seq_match)
        report($sformatf("seq_match %0b, want %0b", seq_match, want.seq_match));
      if (type_match !== want.type_match)
        report($sformatf("type_match %0b, want %0b", type_match, want.type_match));
      if (computed_crc !== want.computed_crc)
        report($sformatf("computed_crc %h, want %h", computed_crc, want.computed_crc));
      if (packet_seq !== want.packet_seq)
        report($sformatf("packet_seq %h, want %h", packet_seq, want.packet_seq));
      if (packet_type !== want.packet_type)
        report($sformatf("packet_type %h, want %h", packet_type, want.packet_type));
    end
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    compared = 0;
    max_len = MAX_DATA_LEN_RESET;
    clear_packet();
  end

  always @(posedge clk) begin
    if (rst) begin
      max_len = MAX_DATA_LEN_RESET;
      clear_packet();
    end else begin
      if (cfg_write) begin
        max_len = cfg_data;
      end
      if (in_valid && !in_stall) begin
        absorb_byte();
      end
      if (out_valid && !out_stall) begin
        compare_verdict();
      end
    end
  end

endmodule

// ===== tb/kermit_packet_checker_core_test.sv =====
`timescale 1ns / 100ps

module kermit_packet_checker_core_test;
  import kpc_pkg::*;
  import kpc_crc_pkg::*;

  // Cycles with no accepted request of any kind before the run is abandoned.
  // The longest legitimate quiet stretch is the receiver's long hold-off (LongHold).
  localparam int IdleLimit = 2000;
  localparam int LongHold = 300;

  typedef enum logic [1:0] {CLEAN, BAD_CHECK, BAD_BODY} damage_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [ByteW-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic [ByteW-1:0] data_byte = '0;
  logic             last_byte = 1'b0;
  logic [ByteW-1:0] expected_seq = '0;
  logic [ByteW-1:0] expected_type = '0;
  logic             out_stall = 1'b0;

  wire              in_stall;
  wire              out_valid;
  wire              packet_ok;
  wire              length_ok;
  wire              check_ok;
  wire              seq_match;
  wire              type_match;
  wire [CrcW-1:0]   computed_crc;
  wire [ByteW-1:0]  packet_seq;
  wire [ByteW-1:0]  packet_type;

  int               mismatches;
  int               pending;
  int               compared;

  // Sender bookkeeping: burst suppresses the per-request gap for a packet.
  bit               burst = 1'b0;
  int               bytes_sent = 0;
  int               packets_sent = 0;
  int               idle_cycles = 0;
  int               holdoffs = 0;
  logic [ByteW-1:0] phase_max [0:3];

  kermit_packet_checker_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .expected_seq (expected_seq),
    .expected_type(expected_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packet_ok    (packet_ok),
    .length_ok    (length_ok),
    .check_ok     (check_ok),
    .seq_match    (seq_match),
    .type_match   (type_match),
    .computed_crc (computed_crc),
    .packet_seq   (packet_seq),
    .packet_type  (packet_type)
  );

  kpc_verdict_checker u_verdicts (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .expected_seq (expected_seq),
    .expected_type(expected_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packet_ok    (packet_ok),
    .length_ok    (length_ok),
    .check_ok     (check_ok),
    .seq_match    (seq_match),
    .type_match   (type_match),
    .computed_crc (computed_crc),
    .packet_seq   (packet_seq),
    .packet_type  (packet_type),
    .mismatches   (mismatches),
    .pending      (pending),
    .compared     (compared)
  );

  always #5 clk = ~clk;

  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  // Offer one byte request, after a random gap unless bursting, and hold the
  // payload steady until the block takes it.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic lst,
                           input logic [ByteW-1:0] es, input logic [ByteW-1:0] et);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    expected_seq <= es;
    expected_type <= et;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // Build a well-formed packet with n data bytes (length field n+5), a correct
  // check stored low byte first, then optionally damage the check or the body.
  task automatic send_packet(input int n, input logic [ByteW-1:0] seq,
                             input logic [ByteW-1:0] typ, input damage_t dmg,
                             input bit match);
    logic [ByteW-1:0] body [0:262];
    logic [CrcW-1:0]  crc;
    int               pos;
    body[0] = rand_byte();
    body[1] = ByteW'(n + 5);
    body[2] = seq;
    body[3] = typ;
    for (int i = 4; i < n + 4; i++) begin
      body[i] = rand_byte();
    end
    crc = '0;
    for (int i = 0; i < n + 4; i++) begin
      crc = crc16_fold(crc, body[i]);
    end
    body[n+4] = crc[7:0];
    body[n+5] = crc[15:8];
    case (dmg)
      BAD_CHECK: begin
        pos = n + 4 + $urandom_range(0, 1);
        body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      BAD_BODY: begin
        pos = $urandom_range(0, n + 3);
        body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
      default: begin
      end
    endcase
    for (int i = 0; i < n + 6; i++) begin
      send_byte(body[i], 1'b0, rand_byte(), rand_byte());
    end
    // End mark: expected fields either match the header or are random.
    send_byte(rand_byte(), 1'b1,
              match ? seq : rand_byte(),
              match ? typ : rand_byte());
    packets_sent++;
  endtask

  // Broken framing: a chosen length field and any number of bytes before the
  // end mark, so short, cut-off and overlong packets all occur.
  task automatic send_noise(input int count, input logic [ByteW-1:0] len);
    for (int i = 0; i < count; i++) begin
      send_byte((i == 1) ? len : rand_byte(), 1'b0, rand_byte(), rand_byte());
    end
    send_byte(rand_byte(), 1'b1, rand_byte(), rand_byte());
    packets_sent++;
  endtask

  // Mostly well-formed packets with random content; the odd long one.
  task automatic random_packet();
    int      pick;
    int      n;
    damage_t dmg;
    burst = ($urandom_range(0, 3) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      n = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 250) : $urandom_range(0, 12);
      pick = $urandom_range(0, 9);
      dmg = (pick < 6) ? CLEAN : (pick < 8) ? BAD_CHECK : BAD_BODY;
      send_packet(n, rand_byte(), rand_byte(), dmg, $urandom_range(0, 1) == 1);
    end else begin
      send_noise($urandom_range(0, 14),
                 $urandom_range(0, 1) ? rand_byte() : ByteW'($urandom_range(0, 8)));
    end
  endtask

  // Drop valid and wait for every verdict to drain, plus a little margin for
  // the result register pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max(input logic [ByteW-1:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int start_bytes;
    int start_packets;
    phase_max[0] = 8'd0;
    phase_max[1] = 8'd255;
    phase_max[2] = ByteW'($urandom_range(1, 254));
    phase_max[3] = MAX_DATA_LEN_RESET;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed packets at the reset maximum, back to back.
    burst = 1'b1;
    // Shortest valid packet, header fields at the extremes, matching.
    send_packet(0, 8'h00, 8'hFF, CLEAN, 1'b1);
    // End mark alone: every header field reads as zero.
    send_byte(8'hFF, 1'b1, 8'hFF, 8'hFF);
    packets_sent++;
    // Length below two: no bytes in the CRC.
    send_byte(8'h01, 1'b0, 8'h00, 8'h00);
    send_byte(8'h01, 1'b0, 8'h00, 8'h00);
    send_byte(8'h0D, 1'b1, 8'h00, 8'h00);
    packets_sent++;
    // Length two: CRC over the start mark only.
    send_byte(8'h01, 1'b0, 8'h00, 8'h00);
    send_byte(8'h02, 1'b0, 8'h00, 8'h00);
    send_byte(8'h41, 1'b0, 8'h00, 8'h00);
    send_byte(8'h0D, 1'b1, 8'h41, 8'h00);
    packets_sent++;
    // Too short to hold its check: length 10, five bytes before the end mark.
    send_byte(8'h01, 1'b0, 8'h00, 8'h00);
    send_byte(8'h0A, 1'b0, 8'h00, 8'h00);
    send_byte(8'h05, 1'b0, 8'h00, 8'h00);
    send_byte(8'h53, 1'b0, 8'h00, 8'h00);
    send_byte(8'h11, 1'b0, 8'h00, 8'h00);
    send_byte(8'h0D, 1'b1, 8'h05, 8'h53);
    packets_sent++;
    settle();

    // Random phases, one maximum length setting each, written while idle.
    for (int ph = 0; ph < 4; ph++) begin
      write_max(phase_max[ph]);
      start_bytes = bytes_sent;
      start_packets = packets_sent;
      while (bytes_sent - start_bytes < 140 || packets_sent - start_packets < 6) begin
        random_packet();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d bytes in %0d packets; maximum length 94, 0, 255, %0d, 94.",
             bytes_sent, packets_sent, phase_max[2]);
    $display("Checked %0d verdicts, with %0d long receiver hold-offs.", compared, holdoffs);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: random stall per result, runs with no stall, and two long
  // hold-offs while the sender keeps going so the block backs up.
  initial begin : receiver
    int hold;
    int taken;
    bit drain;
    taken = 0;
    drain = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == 10 || taken == 30) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        holdoffs++;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          drain = ~drain;
        end
        hold = drain ? 0 : $urandom_range(0, 19);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: count cycles in which no request of any kind is accepted.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timed out after %0d quiet cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
